### hdl/rap_pkg.sv
// ----------------------------------------------------------------------------
// rap_pkg
// Shared constants and types of the RADIUS attribute parser.
// ----------------------------------------------------------------------------
package rap_pkg;

    localparam int MAX_PACKET_BYTES = 4096;

    // byte position counter, holds MAX_PACKET_BYTES itself
    localparam int POS_W = $clog2(MAX_PACKET_BYTES + 1);
    // attribute / sub-attribute end positions
    localparam int AW    = $clog2(MAX_PACKET_BYTES + 512);
    // compare width covering positions and the 16-bit length field
    localparam int CW    = 18;

    localparam int HEADER_BYTES = 20;
    localparam int VSA_MIN_LEN  = 8;

    localparam logic [7:0] ATTR_VENDOR   = 8'd26;
    localparam logic [7:0] ATTR_EAP_MSG  = 8'd79;
    localparam logic [7:0] ATTR_MSG_AUTH = 8'd80;
    localparam logic [7:0] CODE_ACCEPT   = 8'd2;
    localparam logic [7:0] CODE_REJECT   = 8'd3;

    localparam logic [7:0] REG_CHECK_ENABLE   = 8'd0;
    localparam logic [7:0] REG_TARGET_CODE    = 8'd1;
    localparam logic [7:0] REG_VENDOR_ID      = 8'd2;
    localparam logic [7:0] REG_VENDOR_SUBTYPE = 8'd3;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_SHORT_PKT   = 3'd1,
        ST_LEN_EXCEEDS = 3'd2,
        ST_TRUNC_HDR   = 3'd3,
        ST_ATTR_SHORT  = 3'd4,
        ST_VSA_SHORT   = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        VS_IDLE = 2'd0,
        VS_ID   = 2'd1,
        VS_SUB  = 2'd2
    } vstage_t;

    // last field in the lowest bits
    typedef struct packed {
        logic        is_auth_end;
        logic        is_eap;
        logic [7:0]  value_length;
        logic [15:0] value_offset;
        logic        found;
        logic [14:0] attr_count;
        logic [15:0] packet_length;
        logic [7:0]  packet_id;
        logic [7:0]  packet_code;
        logic [2:0]  status;
    } result_t;

    localparam int RES_W   = $bits(result_t);
    localparam int TDATA_W = ((RES_W + 7) / 8) * 8;

endpackage

### hdl/radius_attribute_parser_top.sv
// ----------------------------------------------------------------------------
// radius_attribute_parser_top
// Streams one RADIUS packet per frame and reports header, attribute count,
// status and the location of the configured attribute value.
// ----------------------------------------------------------------------------
// channel   dir  transfer when             payload
// s_axis    in   s_tvalid & s_tready       tdata = data_byte, tlast = last_byte
// m_axis    out  m_tvalid & m_tready       tdata = result fields
// cfg       in   cfg_valid & cfg_ready     cfg_index, cfg_data
//
// One byte per cycle; each byte updates the parse state in the cycle it is
// taken. The result of a frame is registered when its tlast byte is taken.
// A held result stalls the input only when m_tready is low at the same time.
// Reset restores register defaults and clears the parse state; no clear pass.
// ----------------------------------------------------------------------------
module radius_attribute_parser_top
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // data_byte
    input  logic                          s_tlast,   // last_byte
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[2:0] packet_code[10:3] packet_id[18:11] packet_length[34:19]
    // attr_count[49:35] found[50] value_offset[66:51] value_length[74:67]
    // is_eap[75] is_auth_end[76]
    output logic [rap_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [7:0]                    cfg_index,
    input  logic [31:0]                   cfg_data
);
    import rap_pkg::*;

    // configuration
    logic        check_en_reg;
    logic [7:0]  target_code_reg;
    logic [31:0] vendor_id_reg;
    logic [8:0]  vendor_sub_reg;

    // parse state
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [15:0]      decl_len_reg, decl_len_next;
    logic [7:0]       hcode_reg, hcode_next;
    logic [7:0]       hid_reg, hid_next;
    logic [AW-1:0]    next_attr_reg, next_attr_next;
    logic [7:0]       cur_type_reg, cur_type_next;
    logic [7:0]       cur_len_reg, cur_len_next;
    logic [31:0]      vacc_reg, vacc_next;
    logic [AW-1:0]    next_sub_reg, next_sub_next;
    logic [2:0]       walk_err_reg, walk_err_next;
    logic             match_done_reg, match_done_next;
    logic [15:0]      match_off_reg, match_off_next;
    logic [7:0]       match_len_reg, match_len_next;
    logic [1:0]       seen_reg, seen_next;
    logic [14:0]      cnt_reg, cnt_next;
    logic             live_reg, live_next;
    logic             open_reg, open_next;
    logic [POS_W-1:0] base_reg, base_next;
    vstage_t          vstage_reg, vstage_next;
    logic [7:0]       sub_type_reg, sub_type_next;

    logic             out_valid_reg;
    result_t          out_data_reg;
    result_t          res;

    logic             take;
    logic [CW-1:0]    b_c, decl_c, attr_end_c, sub_end_c, nxt_c;
    logic [POS_W-1:0] off;
    logic [31:0]      vacc_sh;
    logic             do_match;
    logic [AW-1:0]    m_pos;
    logic [7:0]       m_len;
    logic [AW-1:0]    m_pos2;
    status_t          status;
    logic             found;

    assign cfg_ready = 1'b1;
    assign s_tready  = !out_valid_reg || m_tready;
    assign take      = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {{(TDATA_W - RES_W){1'b0}}, out_data_reg};

    always_comb
    begin
        pos_next        = pos_reg;
        decl_len_next   = decl_len_reg;
        hcode_next      = hcode_reg;
        hid_next        = hid_reg;
        next_attr_next  = next_attr_reg;
        cur_type_next   = cur_type_reg;
        cur_len_next    = cur_len_reg;
        vacc_next       = vacc_reg;
        next_sub_next   = next_sub_reg;
        walk_err_next   = walk_err_reg;
        match_done_next = match_done_reg;
        match_off_next  = match_off_reg;
        match_len_next  = match_len_reg;
        seen_next       = seen_reg;
        cnt_next        = cnt_reg;
        live_next       = live_reg;
        open_next       = open_reg;
        base_next       = base_reg;
        vstage_next     = vstage_reg;
        sub_type_next   = sub_type_reg;
        do_match        = 1'b0;
        m_pos           = '0;
        m_len           = '0;

        b_c        = CW'(pos_reg);
        decl_c     = CW'(decl_len_reg);
        off        = pos_reg - base_reg;
        vacc_sh    = {vacc_reg[23:0], s_tdata};
        attr_end_c = CW'(base_reg) + CW'(cur_len_reg);
        sub_end_c  = CW'(next_sub_reg) + CW'(1);
        nxt_c      = CW'(next_sub_reg) + CW'(s_tdata);

        if (pos_reg < POS_W'(MAX_PACKET_BYTES))
        begin
            pos_next = pos_reg + POS_W'(1);
            case (pos_reg)
                POS_W'(0): hcode_next = s_tdata;
                POS_W'(1): hid_next = s_tdata;
                POS_W'(2): decl_len_next = {s_tdata, decl_len_reg[7:0]};
                POS_W'(3): decl_len_next = {decl_len_reg[15:8], s_tdata};
                default: ;
            endcase

            decl_c = CW'(decl_len_next);
            if (live_reg && pos_reg >= POS_W'(HEADER_BYTES))
            begin
                if (CW'(next_attr_reg) == b_c)
                begin
                    open_next   = 1'b0;
                    vstage_next = VS_IDLE;
                    if (b_c >= decl_c)
                    begin
                        live_next = 1'b0;
                    end
                    else if (b_c + CW'(1) >= decl_c)
                    begin
                        if (walk_err_reg == 3'd0)
                            walk_err_next = ST_TRUNC_HDR;
                        live_next = 1'b0;
                    end
                    else
                    begin
                        open_next     = 1'b1;
                        base_next     = pos_reg;
                        cur_type_next = s_tdata;
                    end
                end
                else if (open_reg && off == POS_W'(1))
                begin
                    cur_len_next = s_tdata;
                    if (s_tdata < 8'd2)
                    begin
                        if (walk_err_reg == 3'd0)
                            walk_err_next = ST_ATTR_SHORT;
                        live_next = 1'b0;
                        open_next = 1'b0;
                    end
                    else
                    begin
                        if (cur_type_reg == ATTR_VENDOR && s_tdata < 8'(VSA_MIN_LEN)
                            && walk_err_reg == 3'd0)
                            walk_err_next = ST_VSA_SHORT;
                        if (CW'(base_reg) + CW'(s_tdata) > decl_c)
                        begin
                            live_next = 1'b0;
                            open_next = 1'b0;
                        end
                        else
                        begin
                            if (cnt_reg != 15'h7FFF)
                                cnt_next = cnt_reg + 15'd1;
                            next_attr_next = AW'(base_reg) + AW'(s_tdata);
                            if (cur_type_reg == ATTR_EAP_MSG)
                                seen_next[0] = 1'b1;
                            if (cur_type_reg == ATTR_MSG_AUTH)
                                seen_next[1] = 1'b1;
                            if (!match_done_reg && cur_type_reg == target_code_reg)
                            begin
                                if (cur_type_reg != ATTR_VENDOR)
                                begin
                                    do_match = 1'b1;
                                    m_pos    = AW'(base_reg);
                                    m_len    = s_tdata;
                                end
                                else if (s_tdata > 8'(VSA_MIN_LEN))
                                begin
                                    vstage_next = VS_ID;
                                    vacc_next   = '0;
                                end
                            end
                        end
                    end
                end
                else if (open_reg && off >= POS_W'(2))
                begin
                    case (vstage_reg)
                        VS_ID:
                        begin
                            vacc_next = vacc_sh;
                            if (off == POS_W'(5))
                            begin
                                if (vacc_sh == vendor_id_reg)
                                begin
                                    vstage_next   = VS_SUB;
                                    next_sub_next = AW'(base_reg) + AW'(6);
                                end
                                else
                                begin
                                    vstage_next = VS_IDLE;
                                end
                            end
                        end
                        VS_SUB:
                        begin
                            if (b_c == CW'(next_sub_reg))
                            begin
                                if (b_c + CW'(1) >= attr_end_c)
                                begin
                                    do_match = 1'b1;
                                    m_pos    = AW'(base_reg);
                                    m_len    = cur_len_reg;
                                end
                                else
                                begin
                                    sub_type_next = s_tdata;
                                end
                            end
                            else if (b_c == sub_end_c)
                            begin
                                if ({1'b0, sub_type_reg} == vendor_sub_reg)
                                begin
                                    do_match = 1'b1;
                                    m_pos    = next_sub_reg;
                                    m_len    = s_tdata;
                                end
                                else if (s_tdata < 8'd2 || nxt_c >= attr_end_c)
                                begin
                                    do_match = 1'b1;
                                    m_pos    = AW'(base_reg);
                                    m_len    = cur_len_reg;
                                end
                                else
                                begin
                                    next_sub_next = AW'(nxt_c);
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
        end

        m_pos2 = m_pos + AW'(2);
        if (do_match)
        begin
            match_done_next = 1'b1;
            match_off_next  = 16'(m_pos2);
            match_len_next  = (m_len > 8'd2) ? m_len - 8'd2 : 8'd0;
            vstage_next     = VS_IDLE;
        end
    end

    always_comb
    begin
        if (pos_next < POS_W'(HEADER_BYTES))
            status = ST_SHORT_PKT;
        else if (CW'(decl_len_next) > CW'(pos_next))
            status = ST_LEN_EXCEEDS;
        else if (check_en_reg && walk_err_next != 3'd0)
            status = status_t'(walk_err_next);
        else
            status = ST_OK;

        found             = match_done_next && match_len_next != 8'd0;
        res               = '0;
        res.status        = status;
        res.packet_code   = hcode_next;
        res.packet_id     = hid_next;
        res.packet_length = decl_len_next;
        if (status == ST_OK)
        begin
            res.attr_count   = cnt_next;
            res.found        = found;
            res.value_offset = found ? match_off_next : 16'd0;
            res.value_length = found ? match_len_next : 8'd0;
            res.is_eap       = (seen_next == 2'b11);
            res.is_auth_end  = (hcode_next == CODE_ACCEPT) || (hcode_next == CODE_REJECT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            check_en_reg    <= 1'b1;
            target_code_reg <= 8'd80;
            vendor_id_reg   <= 32'hFFFF_FFFF;
            vendor_sub_reg  <= 9'd256;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CHECK_ENABLE:   check_en_reg    <= cfg_data[0];
                REG_TARGET_CODE:    target_code_reg <= cfg_data[7:0];
                REG_VENDOR_ID:      vendor_id_reg   <= cfg_data;
                REG_VENDOR_SUBTYPE: vendor_sub_reg  <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            decl_len_reg   <= '0;
            hcode_reg      <= '0;
            hid_reg        <= '0;
            next_attr_reg  <= AW'(HEADER_BYTES);
            cur_type_reg   <= '0;
            cur_len_reg    <= '0;
            vacc_reg       <= '0;
            next_sub_reg   <= '0;
            walk_err_reg   <= '0;
            match_done_reg <= 1'b0;
            match_off_reg  <= '0;
            match_len_reg  <= '0;
            seen_reg       <= '0;
            cnt_reg        <= '0;
            live_reg       <= 1'b1;
            open_reg       <= 1'b0;
            base_reg       <= '0;
            vstage_reg     <= VS_IDLE;
            sub_type_reg   <= '0;
        end
        else if (take && s_tlast)
        begin
            pos_reg        <= '0;
            decl_len_reg   <= '0;
            hcode_reg      <= '0;
            hid_reg        <= '0;
            next_attr_reg  <= AW'(HEADER_BYTES);
            cur_type_reg   <= '0;
            cur_len_reg    <= '0;
            vacc_reg       <= '0;
            next_sub_reg   <= '0;
            walk_err_reg   <= '0;
            match_done_reg <= 1'b0;
            match_off_reg  <= '0;
            match_len_reg  <= '0;
            seen_reg       <= '0;
            cnt_reg        <= '0;
            live_reg       <= 1'b1;
            open_reg       <= 1'b0;
            base_reg       <= '0;
            vstage_reg     <= VS_IDLE;
            sub_type_reg   <= '0;
        end
        else if (take)
        begin
            pos_reg        <= pos_next;
            decl_len_reg   <= decl_len_next;
            hcode_reg      <= hcode_next;
            hid_reg        <= hid_next;
            next_attr_reg  <= next_attr_next;
            cur_type_reg   <= cur_type_next;
            cur_len_reg    <= cur_len_next;
            vacc_reg       <= vacc_next;
            next_sub_reg   <= next_sub_next;
            walk_err_reg   <= walk_err_next;
            match_done_reg <= match_done_next;
            match_off_reg  <= match_off_next;
            match_len_reg  <= match_len_next;
            seen_reg       <= seen_next;
            cnt_reg        <= cnt_next;
            live_reg       <= live_next;
            open_reg       <= open_next;
            base_reg       <= base_next;
            vstage_reg     <= vstage_next;
            sub_type_reg   <= sub_type_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take && s_tlast)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && s_tlast)
            out_data_reg <= res;
    end

endmodule

### hdl/rap_checker.sv
// ----------------------------------------------------------------------------
// rap_checker
// Port-level checks of the RADIUS attribute parser, bound to the top level.
// ----------------------------------------------------------------------------
module rap_checker
(
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        s_tlast,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [rap_pkg::TDATA_W-1:0] m_tdata
);
    import rap_pkg::*;

    result_t r;
    assign r = result_t'(m_tdata[RES_W-1:0]);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast |=> m_tvalid)
        else $error("no result after last byte transfer");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.status != ST_OK |->
            r.attr_count == 15'd0 && !r.found && r.value_offset == 16'd0
            && r.value_length == 8'd0 && !r.is_eap && !r.is_auth_end)
        else $error("failed packet carries parse fields");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !r.found |-> r.value_offset == 16'd0 && r.value_length == 8'd0)
        else $error("value location without a match");

    a_auth_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && r.status == ST_OK |->
            r.is_auth_end == (r.packet_code == CODE_ACCEPT || r.packet_code == CODE_REJECT))
        else $error("auth end flag does not follow code");

endmodule

bind radius_attribute_parser_top rap_checker u_rap_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

### tb/sv/radius_attribute_parser_top_test.sv
// ----------------------------------------------------------------------------
// radius_attribute_parser_top_test
// Streams RADIUS packets byte by byte into the parser and checks each
// per-packet report against a cycle-free parse model kept in the bench.
// Hand-built packets cover the header, length, walk-error and vendor
// sub-attribute corners; random packets, mostly well formed, follow under
// several register settings. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module radius_attribute_parser_top_test;

    import rap_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } stream_byte_t;

    localparam logic [31:0] DIR_VENDOR  = 32'h0000_2A5C;
    localparam logic [8:0]  DIR_SUBTYPE = 9'd5;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [TDATA_W-1:0]   m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [7:0]           cfg_index = '0;
    logic [31:0]          cfg_data = '0;

    radius_attribute_parser_top dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // register copies
    bit          cfg_check;
    logic [7:0]  cfg_target;
    logic [31:0] cfg_vid;
    logic [8:0]  cfg_subtype;

    // parse state
    int unsigned rx_count;
    logic [15:0] len_field;
    logic [7:0]  hdr_code;
    logic [7:0]  hdr_id;
    int unsigned next_attr_pos;
    logic [7:0]  attr_type;
    logic [7:0]  attr_len;
    logic [31:0] vid_shift;
    int unsigned next_sub_pos;
    status_t     walk_err;
    bit          match_hit;
    logic [15:0] match_off;
    logic [7:0]  match_len;
    logic [1:0]  eap_seen;
    logic [14:0] attr_total;
    bit          walk_on;
    bit          in_attr;
    int unsigned attr_pos;
    vstage_t     vstage;
    logic [7:0]  sub_kind;

    stream_byte_t tx_items[$];
    result_t      predicted_reports[$];
    logic [7:0]   pkt[$];

    stream_byte_t tx_next;
    int           tx_gap;
    int           rx_stall;
    int           rx_pick;
    bit           tx_calm;
    bit           rx_calm;
    int           bytes_queued;
    int           bytes_accepted;
    int           rand_bytes;
    int           mismatches;
    bit           got_report;
    result_t      model_rep;
    result_t      dut_rep;

    task automatic clear_parse();
        rx_count = 0;
        len_field = '0;
        hdr_code = '0;
        hdr_id = '0;
        next_attr_pos = HEADER_BYTES;
        attr_type = '0;
        attr_len = '0;
        vid_shift = '0;
        next_sub_pos = 0;
        walk_err = ST_OK;
        match_hit = 1'b0;
        match_off = '0;
        match_len = '0;
        eap_seen = '0;
        attr_total = '0;
        walk_on = 1'b1;
        in_attr = 1'b0;
        attr_pos = 0;
        vstage = VS_IDLE;
        sub_kind = '0;
    endtask

    task automatic flag_error(input status_t code);
        if (walk_err == ST_OK)
            walk_err = code;
    endtask

    task automatic mark_match(input int unsigned pos, input int unsigned len);
        match_hit = 1'b1;
        match_off = 16'(pos + 2);
        match_len = (len > 2) ? 8'(len - 2) : 8'd0;
        vstage = VS_IDLE;
    endtask

    task automatic walk_vendor(input int unsigned b, input logic [7:0] v,
                               input int unsigned off);
        int unsigned stop;
        int unsigned nxt;
        stop = attr_pos + attr_len;
        if (vstage == VS_ID)
        begin
            vid_shift = {vid_shift[23:0], v};
            if (off == 5)
            begin
                if (vid_shift == cfg_vid)
                begin
                    vstage = VS_SUB;
                    next_sub_pos = attr_pos + 6;
                end
                else
                    vstage = VS_IDLE;
            end
        end
        else if (vstage == VS_SUB)
        begin
            if (b == next_sub_pos)
            begin
                if (b + 1 >= stop)
                    mark_match(attr_pos, attr_len);
                else
                    sub_kind = v;
            end
            else if (b == next_sub_pos + 1)
            begin
                if ({1'b0, sub_kind} == cfg_subtype)
                    mark_match(next_sub_pos, v);
                else if (v < 2)
                    mark_match(attr_pos, attr_len);
                else
                begin
                    nxt = next_sub_pos + v;
                    if (nxt >= stop)
                        mark_match(attr_pos, attr_len);
                    else
                        next_sub_pos = nxt;
                end
            end
        end
    endtask

    task automatic walk_length(input logic [7:0] v);
        attr_len = v;
        if (v < 2)
        begin
            flag_error(ST_ATTR_SHORT);
            walk_on = 1'b0;
            in_attr = 1'b0;
            return;
        end
        if (attr_type == ATTR_VENDOR && v < VSA_MIN_LEN)
            flag_error(ST_VSA_SHORT);
        if (attr_pos + v > len_field)
        begin
            walk_on = 1'b0;
            in_attr = 1'b0;
            return;
        end
        if (attr_total != 15'h7FFF)
            attr_total = attr_total + 1'b1;
        next_attr_pos = attr_pos + v;
        if (attr_type == ATTR_EAP_MSG)
            eap_seen[0] = 1'b1;
        if (attr_type == ATTR_MSG_AUTH)
            eap_seen[1] = 1'b1;
        if (!match_hit && attr_type == cfg_target)
        begin
            if (attr_type != ATTR_VENDOR)
                mark_match(attr_pos, v);
            else if (v > VSA_MIN_LEN)
            begin
                vstage = VS_ID;
                vid_shift = '0;
            end
        end
    endtask

    task automatic walk_byte(input int unsigned b, input logic [7:0] v);
        if (b == 0)
            hdr_code = v;
        else if (b == 1)
            hdr_id = v;
        else if (b == 2)
            len_field[15:8] = v;
        else if (b == 3)
            len_field[7:0] = v;
        if (!walk_on || b < HEADER_BYTES)
            return;
        if (b == next_attr_pos)
        begin
            in_attr = 1'b0;
            vstage = VS_IDLE;
            if (b >= len_field)
                walk_on = 1'b0;
            else if (b + 1 >= len_field)
            begin
                flag_error(ST_TRUNC_HDR);
                walk_on = 1'b0;
            end
            else
            begin
                in_attr = 1'b1;
                attr_pos = b;
                attr_type = v;
            end
        end
        else if (in_attr)
        begin
            if (b - attr_pos == 1)
                walk_length(v);
            else if (b - attr_pos >= 2 && vstage != VS_IDLE)
                walk_vendor(b, v, b - attr_pos);
        end
    endtask

    task automatic parse_step(input logic [7:0] v, input logic last,
                              output bit done, output result_t rep);
        status_t st;
        done = 1'b0;
        rep = '0;
        if (rx_count < MAX_PACKET_BYTES)
        begin
            walk_byte(rx_count, v);
            rx_count++;
        end
        if (!last)
            return;
        if (rx_count < HEADER_BYTES)
            st = ST_SHORT_PKT;
        else if (len_field > rx_count)
            st = ST_LEN_EXCEEDS;
        else if (cfg_check && walk_err != ST_OK)
            st = walk_err;
        else
            st = ST_OK;
        rep.status = st;
        rep.packet_code = hdr_code;
        rep.packet_id = hdr_id;
        rep.packet_length = len_field;
        if (st == ST_OK)
        begin
            rep.attr_count = attr_total;
            rep.found = match_hit && match_len != 0;
            rep.value_offset = rep.found ? match_off : 16'd0;
            rep.value_length = rep.found ? match_len : 8'd0;
            rep.is_eap = (eap_seen == 2'b11);
            rep.is_auth_end = (hdr_code == CODE_ACCEPT || hdr_code == CODE_REJECT);
        end
        done = 1'b1;
        clear_parse();
    endtask

    function automatic int pick_gap(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tlast <= 1'b0;
            tx_gap <= 0;
        end
        else if (!s_tvalid || s_tready)
        begin
            if (tx_gap > 0)
            begin
                s_tvalid <= 1'b0;
                tx_gap <= tx_gap - 1;
            end
            else if (tx_items.size() > 0)
            begin
                tx_next = tx_items.pop_front();
                s_tvalid <= 1'b1;
                s_tdata <= tx_next.data;
                s_tlast <= tx_next.last;
                tx_gap <= pick_gap(tx_calm);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            rx_stall <= 0;
        end
        else if (rx_stall > 0)
        begin
            m_tready <= 1'b0;
            rx_stall <= rx_stall - 1;
        end
        else
        begin
            rx_pick = pick_gap(rx_calm);
            m_tready <= (rx_pick == 0);
            rx_stall <= (rx_pick > 0) ? rx_pick - 1 : 0;
        end
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] seen);
        if (seen !== want)
        begin
            $error("%s expected %0d got %0d", name, want, seen);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            parse_step(s_tdata, s_tlast, got_report, model_rep);
            bytes_accepted++;
            if (got_report)
                predicted_reports.push_back(model_rep);
        end
        if (rst_n && m_tvalid && m_tready)
        begin
            dut_rep = result_t'(m_tdata[RES_W-1:0]);
            if (predicted_reports.size() == 0)
            begin
                $error("report transfer with none predicted");
                mismatches++;
            end
            else
            begin
                model_rep = predicted_reports.pop_front();
                check_field("status", model_rep.status, dut_rep.status);
                check_field("packet_code", model_rep.packet_code, dut_rep.packet_code);
                check_field("packet_id", model_rep.packet_id, dut_rep.packet_id);
                check_field("packet_length", model_rep.packet_length,
                            dut_rep.packet_length);
                check_field("attr_count", model_rep.attr_count, dut_rep.attr_count);
                check_field("found", model_rep.found, dut_rep.found);
                check_field("value_offset", model_rep.value_offset,
                            dut_rep.value_offset);
                check_field("value_length", model_rep.value_length,
                            dut_rep.value_length);
                check_field("is_eap", model_rep.is_eap, dut_rep.is_eap);
                check_field("is_auth_end", model_rep.is_auth_end, dut_rep.is_auth_end);
            end
        end
    end

    task automatic write_reg(input logic [7:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_CHECK_ENABLE:   cfg_check = val[0];
            REG_TARGET_CODE:    cfg_target = val[7:0];
            REG_VENDOR_ID:      cfg_vid = val;
            REG_VENDOR_SUBTYPE: cfg_subtype = val[8:0];
            default: ;
        endcase
    endtask

    task automatic apply_config(input bit chk, input logic [7:0] tgt,
                                input logic [31:0] vid, input logic [8:0] sub);
        write_reg(REG_CHECK_ENABLE, {31'd0, chk});
        write_reg(REG_TARGET_CODE, {24'd0, tgt});
        write_reg(REG_VENDOR_ID, vid);
        write_reg(REG_VENDOR_SUBTYPE, {23'd0, sub});
    endtask

    // wait for every byte and report, then let the bench idle before returning
    task automatic drain();
        int waited;
        waited = 0;
        while (bytes_accepted != bytes_queued)
            @(posedge clk);
        while (predicted_reports.size() != 0 && waited < 2000)
        begin
            @(posedge clk);
            waited++;
        end
        if (predicted_reports.size() != 0)
        begin
            $error("%0d reports never arrived", predicted_reports.size());
            mismatches++;
            predicted_reports.delete();
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic start_pkt(input logic [7:0] code, input logic [7:0] id);
        pkt.delete();
        pkt.push_back(code);
        pkt.push_back(id);
        pkt.push_back(8'd0);
        pkt.push_back(8'd0);
        repeat (16) pkt.push_back(8'($urandom));
    endtask

    task automatic set_len(input int n);
        pkt[2] = 8'(n >> 8);
        pkt[3] = 8'(n);
    endtask

    task automatic close_pkt();
        set_len(pkt.size());
    endtask

    // also used for vendor sub-attributes, which share the layout
    task automatic put_attr(input logic [7:0] kind, input int len);
        pkt.push_back(kind);
        pkt.push_back(8'(len));
        repeat ((len > 2) ? len - 2 : 0) pkt.push_back(8'($urandom));
    endtask

    task automatic put_vsa_head(input logic [31:0] vid, input int body_len);
        pkt.push_back(ATTR_VENDOR);
        pkt.push_back(8'(body_len + 6));
        pkt.push_back(vid[31:24]);
        pkt.push_back(vid[23:16]);
        pkt.push_back(vid[15:8]);
        pkt.push_back(vid[7:0]);
    endtask

    task automatic put_random_vsa(input logic [31:0] vid);
        logic [7:0] body[$];
        int sl;
        repeat ($urandom_range(0, 3))
        begin
            sl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            body.push_back($urandom_range(0, 1) ? cfg_subtype[7:0] : 8'($urandom));
            body.push_back(8'(sl));
            repeat ((sl > 2) ? sl - 2 : 0) body.push_back(8'($urandom));
        end
        if ($urandom_range(0, 4) == 0)
            body.push_back(8'($urandom));
        put_vsa_head(vid, body.size());
        foreach (body[i])
            pkt.push_back(body[i]);
    endtask

    task automatic send_pkt(input bit counted);
        stream_byte_t item;
        foreach (pkt[i])
        begin
            item.data = pkt[i];
            item.last = (i == pkt.size() - 1);
            tx_items.push_back(item);
        end
        bytes_queued += pkt.size();
        if (counted)
            rand_bytes += pkt.size();
        tx_calm = ($urandom_range(0, 7) == 0);
        rx_calm = ($urandom_range(0, 7) == 0);
    endtask

    task automatic run_directed(input bit with_big);
        pkt.delete();
        pkt.push_back(8'hA5);
        send_pkt(0);
        start_pkt(8'd1, 8'd0);
        void'(pkt.pop_back());
        send_pkt(0);
        start_pkt(CODE_ACCEPT, 8'hFF);
        close_pkt();
        send_pkt(0);
        start_pkt(8'd1, 8'd1);
        put_attr(8'd1, 4);
        set_len(16'hFFFF);
        send_pkt(0);
        // EAP pair, first 79 has an empty value
        start_pkt(CODE_REJECT, 8'h00);
        put_attr(ATTR_EAP_MSG, 2);
        put_attr(ATTR_EAP_MSG, 6);
        put_attr(ATTR_MSG_AUTH, 18);
        close_pkt();
        send_pkt(0);
        // vendor: second sub-attribute matches
        start_pkt(8'd1, 8'd7);
        put_attr(8'd1, 3);
        put_vsa_head(DIR_VENDOR, 8);
        put_attr(8'd9, 4);
        put_attr(DIR_SUBTYPE[7:0], 4);
        close_pkt();
        send_pkt(0);
        // vendor: no sub-attribute matches, walk ends at the attribute end
        start_pkt(8'd4, 8'd8);
        put_vsa_head(DIR_VENDOR, 7);
        put_attr(8'd9, 4);
        put_attr(8'd7, 3);
        close_pkt();
        send_pkt(0);
        // vendor: sub-attribute length below 2
        start_pkt(8'd1, 8'd9);
        put_vsa_head(DIR_VENDOR, 4);
        put_attr(8'd9, 1);
        pkt.push_back(8'($urandom));
        pkt.push_back(8'($urandom));
        close_pkt();
        send_pkt(0);
        // vendor: last sub-attribute header does not fit
        start_pkt(8'd1, 8'd10);
        put_vsa_head(DIR_VENDOR, 3);
        put_attr(8'd9, 2);
        pkt.push_back(DIR_SUBTYPE[7:0]);
        close_pkt();
        send_pkt(0);
        // vendor: matching sub-attribute with empty value
        start_pkt(8'd1, 8'd11);
        put_vsa_head(DIR_VENDOR, 4);
        put_attr(DIR_SUBTYPE[7:0], 2);
        put_attr(8'd9, 2);
        close_pkt();
        send_pkt(0);
        // wrong vendor first, right vendor second
        start_pkt(8'd1, 8'd12);
        put_vsa_head(~DIR_VENDOR, 4);
        put_attr(DIR_SUBTYPE[7:0], 4);
        put_vsa_head(DIR_VENDOR, 4);
        put_attr(DIR_SUBTYPE[7:0], 4);
        close_pkt();
        send_pkt(0);
        // attribute lengths 0 and 1
        start_pkt(8'd1, 8'd13);
        put_attr(8'd1, 4);
        put_attr(8'd2, 0);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        close_pkt();
        send_pkt(0);
        start_pkt(8'd1, 8'd14);
        put_attr(8'd2, 1);
        put_attr(8'd3, 4);
        close_pkt();
        send_pkt(0);
        // short vendor attribute, then one of exactly 8 bytes
        start_pkt(8'd1, 8'd15);
        put_vsa_head(DIR_VENDOR, 1);
        pkt.push_back(DIR_SUBTYPE[7:0]);
        close_pkt();
        send_pkt(0);
        start_pkt(8'd1, 8'd16);
        put_vsa_head(DIR_VENDOR, 2);
        put_attr(DIR_SUBTYPE[7:0], 2);
        close_pkt();
        send_pkt(0);
        // truncated attribute header
        start_pkt(8'd1, 8'd17);
        pkt.push_back(8'd1);
        close_pkt();
        send_pkt(0);
        // attribute overruns the length field
        start_pkt(8'd1, 8'd18);
        put_attr(8'd1, 10);
        set_len(25);
        send_pkt(0);
        // trailing bytes past the length field
        start_pkt(8'd5, 8'd19);
        put_attr(ATTR_MSG_AUTH, 18);
        close_pkt();
        repeat (5) pkt.push_back(8'($urandom));
        send_pkt(0);
        if (with_big)
        begin
            start_pkt(8'd1, 8'd2);
            repeat (15) put_attr(8'd1, 255);
            put_attr(8'd1, 251);
            close_pkt();
            repeat (4) pkt.push_back(8'($urandom));
            send_pkt(0);
        end
    endtask

    task automatic make_random_pkt();
        int sel;
        int k;
        sel = $urandom_range(0, 7);
        start_pkt((sel < 6) ? 8'(sel) : 8'($urandom), 8'($urandom));
        repeat ($urandom_range(0, 6))
        begin
            case ($urandom_range(0, 8))
                0, 1, 2: put_attr(8'($urandom), $urandom_range(2, 12));
                3, 4:    put_attr(cfg_target, $urandom_range(2, 10));
                5, 6:    put_random_vsa(($urandom_range(0, 3) != 0) ? cfg_vid : 32'($urandom));
                7:       put_attr(ATTR_EAP_MSG, $urandom_range(2, 10));
                default: put_attr(ATTR_MSG_AUTH, 18);
            endcase
        end
        close_pkt();
        if ($urandom_range(0, 9) < 3)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    k = $urandom_range(1, pkt.size());
                    while (pkt.size() > k)
                        void'(pkt.pop_back());
                end
                1: set_len($urandom_range(20, pkt.size()));
                2: set_len($urandom_range(0, 16'hFFFF));
                3: repeat ($urandom_range(1, 8)) pkt.push_back(8'($urandom));
                4:
                begin
                    if (pkt.size() > 20)
                        pkt[$urandom_range(20, pkt.size() - 1)] = 8'($urandom);
                end
                default:
                begin
                    put_attr(8'($urandom), $urandom_range(0, 1));
                    put_attr(8'd1, 4);
                    close_pkt();
                end
            endcase
        end
        send_pkt(1);
    endtask

    initial
    begin
        int ph;
        int pick;
        logic [7:0] tgt;
        cfg_check = 1'b1;
        cfg_target = ATTR_MSG_AUTH;
        cfg_vid = 32'hFFFF_FFFF;
        cfg_subtype = 9'd256;
        clear_parse();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        apply_config(1'b1, ATTR_VENDOR, DIR_VENDOR, DIR_SUBTYPE);
        run_directed(1'b0);
        drain();
        apply_config(1'b0, ATTR_EAP_MSG, 32'h0, 9'd256);
        run_directed(1'b0);
        drain();

        ph = 0;
        while (bytes_queued < 1750 || rand_bytes == 0)
        begin
            pick = $urandom_range(0, 3);
            tgt = (pick < 2) ? ATTR_VENDOR : (pick == 2) ? ATTR_MSG_AUTH : 8'($urandom);
            case (ph)
                0: apply_config(1'b1, ATTR_MSG_AUTH, 32'hFFFF_FFFF, 9'd256);
                1: apply_config(1'b0, ATTR_VENDOR, 32'h0, 9'd0);
                2: apply_config(1'b1, ATTR_VENDOR, 32'hFFFF_FFFF, 9'd255);
                3: apply_config(1'b0, 8'hFF, $urandom, 9'd256);
                4: apply_config(1'b1, 8'h00, $urandom, 9'($urandom_range(0, 256)));
                default: apply_config(1'($urandom_range(0, 1)), tgt, $urandom,
                                      9'($urandom_range(0, 256)));
            endcase
            repeat ($urandom_range(6, 16))
                make_random_pkt();
            drain();
            ph++;
        end

        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("radius_attribute_parser_top_test: PASS");
        else
            $display("radius_attribute_parser_top_test: FAIL");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("radius_attribute_parser_top_test: FAIL");
        $finish;
    end

endmodule
